### src/bcgc_pkg.sv
// Shared types and constants for the battery charge gating controller.
package bcgc_pkg;

	localparam int TempWidth = 16;
	localparam int CodeWidth = 16;
	localparam int CfgIdxWidth = 3;

	// Configuration register indexes.
	localparam logic [CfgIdxWidth-1:0] CfgStopTempHigh = 3'd0;
	localparam logic [CfgIdxWidth-1:0] CfgStopTempLow = 3'd1;
	localparam logic [CfgIdxWidth-1:0] CfgAllowTempHigh = 3'd2;
	localparam logic [CfgIdxWidth-1:0] CfgAllowTempLow = 3'd3;
	localparam logic [CfgIdxWidth-1:0] CfgCurrentUsb = 3'd4;
	localparam logic [CfgIdxWidth-1:0] CfgCurrentPd = 3'd5;
	localparam logic [CfgIdxWidth-1:0] CfgCurrentStopped = 3'd6;

	// Register reset values.
	localparam logic [TempWidth-1:0] StopTempHighRst = 16'd3281;
	localparam logic [TempWidth-1:0] StopTempLowRst = 16'd2731;
	localparam logic [TempWidth-1:0] AllowTempHighRst = 16'd3231;
	localparam logic [TempWidth-1:0] AllowTempLowRst = 16'd2781;

	// Item function codes.
	localparam logic FuncPoll = 1'b0;
	localparam logic FuncPlugIn = 1'b1;

	// Gauge full report codes.
	localparam logic [1:0] FullNot = 2'd0;
	localparam logic [1:0] FullYes = 2'd1;

	typedef struct packed {
		logic [TempWidth-1:0] stop_temp_high;
		logic [TempWidth-1:0] stop_temp_low;
		logic [TempWidth-1:0] allow_temp_high;
		logic [TempWidth-1:0] allow_temp_low;
		logic [CodeWidth-1:0] current_usb_default;
		logic [CodeWidth-1:0] current_power_delivery;
		logic [CodeWidth-1:0] current_stopped;
	} cfg_t;

	typedef struct packed {
		logic fully_charged;
		logic needs_charge;
		logic temp_stopped;
		logic temp_allowed;
	} flags_t;

	typedef struct packed {
		logic                 func;
		logic [1:0]           full_status;
		logic                 temp_valid;
		logic [TempWidth-1:0] temperature;
		logic                 charger_ok;
		logic [1:0]           source_type;
		logic                 first_ack;
		logic                 second_ack;
	} item_t;

	typedef struct packed {
		logic                 first_cmd_valid;
		logic [CodeWidth-1:0] first_cmd_current;
		logic                 second_cmd_valid;
		logic [CodeWidth-1:0] second_cmd_current;
	} cmds_t;

endpackage

### src/bcgc_eval.sv
// Evaluation of one item: full check, temperature check and plug-in handling.
module bcgc_eval import bcgc_pkg::*; (
	input  cfg_t   cfg,
	input  flags_t flags,
	input  item_t  item,
	output cmds_t  cmds,
	output flags_t flags_next
);

	logic [CodeWidth-1:0] enable_code;
	logic                 in_allow;
	logic                 in_stop;
	flags_t               f1;
	logic                 full_issue;
	logic [CodeWidth-1:0] full_code;
	logic                 full_ok;
	logic                 temp_issue;
	logic [CodeWidth-1:0] temp_code;
	logic                 temp_ack;
	logic                 temp_ok;
	flags_t               f2;

	assign enable_code = item.source_type[1] ? cfg.current_power_delivery
		: cfg.current_usb_default;
	assign in_allow = (item.temperature < cfg.allow_temp_high)
		&& (item.temperature > cfg.allow_temp_low);
	assign in_stop = (item.temperature >= cfg.stop_temp_high)
		|| (item.temperature <= cfg.stop_temp_low);

	// Full check of a poll; a refused command leaves the flags as they were.
	always_comb begin
		f1 = flags;
		full_issue = 1'b0;
		full_code = '0;
		full_ok = 1'b0;
		if (item.full_status == FullYes) begin
			full_issue = !flags.fully_charged;
			full_code = cfg.current_stopped;
			full_ok = !full_issue || item.first_ack;
			if (full_ok) begin
				f1.fully_charged = 1'b1;
				f1.needs_charge = 1'b0;
			end
		end else if (item.full_status == FullNot) begin
			full_issue = !flags.needs_charge && !flags.temp_stopped && item.charger_ok;
			full_code = enable_code;
			full_ok = !full_issue || item.first_ack;
			if (full_ok) begin
				f1.fully_charged = 1'b0;
				f1.needs_charge = 1'b1;
			end
		end
	end

	// Temperature check; its command takes the slot after the full check's.
	always_comb begin
		f2 = f1;
		temp_issue = 1'b0;
		temp_code = '0;
		temp_ack = full_issue ? item.second_ack : item.first_ack;
		temp_ok = 1'b0;
		if (item.temp_valid) begin
			if (in_stop) begin
				temp_issue = !f1.temp_stopped;
				temp_code = cfg.current_stopped;
				temp_ok = !temp_issue || temp_ack;
				if (temp_ok) begin
					f2.temp_stopped = 1'b1;
					f2.temp_allowed = 1'b0;
				end
			end else if (in_allow) begin
				temp_issue = !f1.temp_allowed && !f1.fully_charged && item.charger_ok;
				temp_code = enable_code;
				temp_ok = !temp_issue || temp_ack;
				if (temp_ok) begin
					f2.temp_stopped = 1'b0;
					f2.temp_allowed = 1'b1;
				end
			end
		end
	end

	always_comb begin
		cmds = '0;
		flags_next = f2;
		if (item.func == FuncPlugIn) begin
			flags_next = flags;
			flags_next.fully_charged = 1'b0;
			flags_next.needs_charge = 1'b0;
			if (item.charger_ok && item.temp_valid && in_allow) begin
				cmds.first_cmd_valid = 1'b1;
				cmds.first_cmd_current = enable_code;
			end
		end else begin
			if (full_issue) begin
				cmds.first_cmd_valid = 1'b1;
				cmds.first_cmd_current = full_code;
				if (temp_issue) begin
					cmds.second_cmd_valid = 1'b1;
					cmds.second_cmd_current = temp_code;
				end
			end else if (temp_issue) begin
				cmds.first_cmd_valid = 1'b1;
				cmds.first_cmd_current = temp_code;
			end
		end
	end

endmodule

### src/bcgc_cfg.sv
// Configuration register file of the battery charge gating controller.
module bcgc_cfg import bcgc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [TempWidth-1:0]   cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_temp_high <= StopTempHighRst;
			cfg_q.stop_temp_low <= StopTempLowRst;
			cfg_q.allow_temp_high <= AllowTempHighRst;
			cfg_q.allow_temp_low <= AllowTempLowRst;
			cfg_q.current_usb_default <= '0;
			cfg_q.current_power_delivery <= '0;
			cfg_q.current_stopped <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgStopTempHigh: cfg_q.stop_temp_high <= cfg_data;
				CfgStopTempLow: cfg_q.stop_temp_low <= cfg_data;
				CfgAllowTempHigh: cfg_q.allow_temp_high <= cfg_data;
				CfgAllowTempLow: cfg_q.allow_temp_low <= cfg_data;
				CfgCurrentUsb: cfg_q.current_usb_default <= cfg_data;
				CfgCurrentPd: cfg_q.current_power_delivery <= cfg_data;
				CfgCurrentStopped: cfg_q.current_stopped <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/battery_charge_gating_controller_top.sv
// Top level of the battery charge gating controller.
//
// Channel   Handshake              Payload
// input     in_valid / in_ready    func .. second_ack
// output    out_valid / out_ready  first_cmd_valid .. is_temp_allowed
// config    cfg_we                 cfg_index, cfg_data
//
// An item is held in the input register and is evaluated against the
// flag registers on its way into the output register; one item per cycle
// is sustained while the output is not stalled. The flags update as the beat
// enters the output register, so the next item already sees them. A stalled
// output holds its beat while the input register still takes one more item.
// Reset restores the register defaults and clears the flag register flags_q.
module battery_charge_gating_controller_top import bcgc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [TempWidth-1:0]   cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   func,
	input  logic [1:0]             full_status,
	input  logic                   temp_valid,
	input  logic [TempWidth-1:0]   temperature,
	input  logic                   charger_ok,
	input  logic [1:0]             source_type,
	input  logic                   first_ack,
	input  logic                   second_ack,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   first_cmd_valid,
	output logic [CodeWidth-1:0]   first_cmd_current,
	output logic                   second_cmd_valid,
	output logic [CodeWidth-1:0]   second_cmd_current,
	output logic                   is_fully_charged,
	output logic                   is_needing_charge,
	output logic                   is_temp_stopped,
	output logic                   is_temp_allowed
);

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	flags_t flags_q;
	flags_t flags_next;
	cmds_t  cmds;
	cmds_t  cmds_s2;
	flags_t flags_s2;
	logic   valid_s2;
	logic   advance;

	bcgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcgc_eval u_eval (
		.cfg        (cfg),
		.flags      (flags_q),
		.item       (item_s1),
		.cmds       (cmds),
		.flags_next (flags_next)
	);

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				flags_q <= flags_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.func <= func;
			item_s1.full_status <= full_status;
			item_s1.temp_valid <= temp_valid;
			item_s1.temperature <= temperature;
			item_s1.charger_ok <= charger_ok;
			item_s1.source_type <= source_type;
			item_s1.first_ack <= first_ack;
			item_s1.second_ack <= second_ack;
		end
		if (advance) begin
			cmds_s2 <= cmds;
			flags_s2 <= flags_next;
		end
	end

	assign out_valid = valid_s2;
	assign first_cmd_valid = cmds_s2.first_cmd_valid;
	assign first_cmd_current = cmds_s2.first_cmd_current;
	assign second_cmd_valid = cmds_s2.second_cmd_valid;
	assign second_cmd_current = cmds_s2.second_cmd_current;
	assign is_fully_charged = flags_s2.fully_charged;
	assign is_needing_charge = flags_s2.needs_charge;
	assign is_temp_stopped = flags_s2.temp_stopped;
	assign is_temp_allowed = flags_s2.temp_allowed;

endmodule
